// File: design/fpv_pkg.sv
`default_nettype none

package fpv_pkg;

    // Field and state widths
    localparam int BYTE_W     = 8;
    localparam int POS_W      = 11;
    localparam int LEN_W      = 12;
    localparam int TOT_W      = 13;
    localparam int OFF_W      = 9;
    localparam int CMD_W      = 16;
    localparam int CNT_W      = 32;
    localparam int CRC8_W     = 8;
    localparam int CRC16_W    = 16;
    localparam int LIMIT_W    = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Frame layout
    localparam int MAX_PAYLOAD    = 512;
    localparam int OVERHEAD_BYTES = 17;
    localparam int PAYLOAD_START  = 15;
    localparam int LEN_LO_POS     = 1;
    localparam int LEN_HI_POS     = 2;
    localparam int HDR_CRC_POS    = 3;
    localparam int CMD_LO_POS     = 13;
    localparam int CMD_HI_POS     = 14;

    localparam logic [POS_W-1:0]   POS_TOP    = '1;
    localparam logic [CRC8_W-1:0]  CRC8_POLY  = 8'h8C;
    localparam logic [CRC16_W-1:0] CRC16_POLY = 16'h8408;

    // Register reset values
    localparam logic [BYTE_W-1:0]  START_BYTE_RST = 8'h5A;
    localparam logic [CRC8_W-1:0]  HDR_SEED_RST   = 8'h77;
    localparam logic [CRC16_W-1:0] FRAME_SEED_RST = 16'h1862;
    localparam logic [LIMIT_W-1:0] LIMIT_RST      = 10'd512;

    typedef enum logic [2:0] {
        VERDICT_OK        = 3'd0,
        VERDICT_START     = 3'd1,
        VERDICT_LENGTH    = 3'd2,
        VERDICT_HDR_CRC   = 3'd3,
        VERDICT_FRAME_CRC = 3'd4
    } verdict_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_BYTE    = 2'd0,
        REG_HDR_SEED      = 2'd1,
        REG_FRAME_SEED    = 2'd2,
        REG_PAYLOAD_LIMIT = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_VERDICT = 1'b1
    } item_kind_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  start_byte;
        logic [CRC8_W-1:0]  hdr_seed;
        logic [CRC16_W-1:0] frame_seed;
        logic [LIMIT_W-1:0] payload_limit;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } in_word_t;

    typedef struct packed {
        item_kind_t         kind;
        logic [BYTE_W-1:0]  value;
        logic [OFF_W-1:0]   offset;
        verdict_t           verdict;
        logic [CMD_W-1:0]   command;
        logic [LEN_W-1:0]   size;
        logic [CNT_W-1:0]   good;
        logic [CNT_W-1:0]   bad;
    } result_t;

    // Reflected CRC-8, one byte
    function automatic logic [CRC8_W-1:0] crc8_byte(input logic [CRC8_W-1:0] c,
                                                    input logic [BYTE_W-1:0] b);
        logic [CRC8_W-1:0] v;
        v = c ^ b;
        for (int i = 0; i < BYTE_W; i++)
        begin
            v = v[0] ? ((v >> 1) ^ CRC8_POLY) : (v >> 1);
        end
        return v;
    endfunction

    // Reflected CRC-16, one byte
    function automatic logic [CRC16_W-1:0] crc16_byte(input logic [CRC16_W-1:0] c,
                                                      input logic [BYTE_W-1:0] b);
        logic [CRC16_W-1:0] v;
        v = c ^ {{(CRC16_W-BYTE_W){1'b0}}, b};
        for (int i = 0; i < BYTE_W; i++)
        begin
            v = v[0] ? ((v >> 1) ^ CRC16_POLY) : (v >> 1);
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// File: design/framed_packet_validator.sv
// Channel  | Handshake                   | Word
// ---------+-----------------------------+-------------------------------------------
// input    | in_valid / in_ready         | rx_byte, end_of_datagram
// output   | out_valid / out_ready       | item_kind, payload_value, payload_offset,
//          |                             | verdict, command_word, payload_size,
//          |                             | good_frames, bad_frames
// config   | cfg_write (no wait)         | cfg_index, cfg_data
//
// Up to one word per cycle in and out while out_ready is high; a result is loaded into the
// output register after its word leaves the input register (input, then result register).
// The frame check between the two registers does one byte of CRC-8 and CRC-16 per taken word.
// Reset clears position, counters and both stage valid flags; no clearing pass.
// With out_ready low the result holds, the input register fills with one word and
// in_ready then drops until the result is taken.
`default_nettype none

module framed_packet_validator
    import fpv_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // byte input
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [BYTE_W-1:0]     rx_byte,
    input  wire logic                  end_of_datagram,
    // result output
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       item_kind,
    output logic [BYTE_W-1:0]          payload_value,
    output logic [OFF_W-1:0]           payload_offset,
    output logic [2:0]                 verdict,
    output logic [CMD_W-1:0]           command_word,
    output logic [LEN_W-1:0]           payload_size,
    output logic [CNT_W-1:0]           good_frames,
    output logic [CNT_W-1:0]           bad_frames,
    // configuration writes
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t     cfg;
    logic     s_valid;
    in_word_t s_word;
    logic     s_take;
    logic     res_valid;
    logic     res_ready;
    result_t  res;
    result_t  out_res;

    // The user must write settings only while idle; the block does not enforce it; seeds are sampled on the first byte
    fpv_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Hold the accepted word
    fpv_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (rx_byte),
        .in_last  (end_of_datagram),
        .s_valid  (s_valid),
        .s_word   (s_word),
        .s_take   (s_take)
    );

    // Advance the frame state by one byte; emit a payload word or the verdict when one is due
    fpv_frame_check u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .s_valid   (s_valid),
        .s_word    (s_word),
        .s_take    (s_take),
        .res_ready (res_ready),
        .res_valid (res_valid),
        .res       (res)
    );

    // Hold the result until the consumer takes it
    fpv_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign item_kind      = out_res.kind;
    assign payload_value  = out_res.value;
    assign payload_offset = out_res.offset;
    assign verdict        = out_res.verdict;
    assign command_word   = out_res.command;
    assign payload_size   = out_res.size;
    assign good_frames    = out_res.good;
    assign bad_frames     = out_res.bad;

endmodule

`default_nettype wire

// File: design/fpv_cfg_regs.sv
`default_nettype none

module fpv_cfg_regs
    import fpv_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_START_BYTE:    cfg_next.start_byte    = cfg_data[BYTE_W-1:0];
                REG_HDR_SEED:      cfg_next.hdr_seed      = cfg_data[CRC8_W-1:0];
                REG_FRAME_SEED:    cfg_next.frame_seed    = cfg_data[CRC16_W-1:0];
                REG_PAYLOAD_LIMIT: cfg_next.payload_limit = cfg_data[LIMIT_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_byte    <= START_BYTE_RST;
            cfg_reg.hdr_seed      <= HDR_SEED_RST;
            cfg_reg.frame_seed    <= FRAME_SEED_RST;
            cfg_reg.payload_limit <= LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: design/fpv_in_stage.sv
`default_nettype none

module fpv_in_stage
    import fpv_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [BYTE_W-1:0] in_data,
    input  wire logic              in_last,
    output logic                   s_valid,
    output in_word_t               s_word,
    input  wire logic              s_take
);

    logic     valid_reg;
    logic     valid_next;
    in_word_t word_reg;
    logic     accept;

    // Take a new word when empty or when the held word leaves this cycle
    assign in_ready = !valid_reg || s_take;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (s_take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg.data <= in_data;
            word_reg.last <= in_last;
        end
    end

    assign s_valid = valid_reg;
    assign s_word  = word_reg;

endmodule

`default_nettype wire

// File: design/fpv_frame_check.sv
`default_nettype none

module fpv_frame_check
    import fpv_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire cfg_t     cfg,
    input  wire logic     s_valid,
    input  wire in_word_t s_word,
    output logic          s_take,
    input  wire logic     res_ready,
    output logic          res_valid,
    output result_t       res
);

    // Control state
    logic [POS_W-1:0]   pos_reg,      pos_next;
    logic               start_ok_reg, start_ok_next;
    logic [CNT_W-1:0]   good_reg,     good_next;
    logic [CNT_W-1:0]   bad_reg,      bad_next;
    // Frame payload state, always written before use within a datagram
    logic [CRC8_W-1:0]  hcrc_reg,     hcrc_next;
    logic               hmatch_reg,   hmatch_next;
    logic [CRC16_W-1:0] fcrc_reg,     fcrc_next;
    logic [LEN_W-1:0]   len_reg,      len_next;
    logic [CMD_W-1:0]   cmd_reg,      cmd_next;
    logic [CRC16_W-1:0] latch_reg,    latch_next;
    logic [CRC16_W-1:0] trail_reg,    trail_next;

    logic               first;
    logic [CRC8_W-1:0]  hcrc_in;
    logic [CRC16_W-1:0] fcrc_in;
    logic [TOT_W-1:0]   pos_w, pos_p1, pos_p2, total, pay_end;
    logic               len_ok, in_window, emit;
    verdict_t           vd;
    logic [BYTE_W-1:0]  b;

    assign s_take = s_valid && res_ready;
    assign b      = s_word.data;

    always_comb
    begin
        first   = (pos_reg == '0);
        hcrc_in = first ? cfg.hdr_seed : hcrc_reg;
        fcrc_in = first ? cfg.frame_seed : fcrc_reg;
        pos_w   = TOT_W'(pos_reg);
        pos_p1  = pos_w + TOT_W'(1);
        pos_p2  = pos_w + TOT_W'(2);

        start_ok_next = first ? (b == cfg.start_byte) : start_ok_reg;
        hcrc_next     = (pos_reg < POS_W'(HDR_CRC_POS)) ? crc8_byte(hcrc_in, b) : hcrc_reg;
        hmatch_next   = (pos_reg == POS_W'(HDR_CRC_POS)) ? (hcrc_reg == b) : hmatch_reg;

        // Length reads as zero until its bytes arrive
        len_next = first ? '0 : len_reg;
        if (pos_reg == POS_W'(LEN_LO_POS))
        begin
            len_next = {len_reg[LEN_W-1:BYTE_W], b};
        end
        if (pos_reg == POS_W'(LEN_HI_POS))
        begin
            len_next = {b[LEN_W-BYTE_W-1:0], len_reg[BYTE_W-1:0]};
        end

        cmd_next = cmd_reg;
        if (pos_reg == POS_W'(CMD_LO_POS))
        begin
            cmd_next = {cmd_reg[CMD_W-1:BYTE_W], b};
        end
        if (pos_reg == POS_W'(CMD_HI_POS))
        begin
            cmd_next = {b, cmd_reg[BYTE_W-1:0]};
        end

        // Frame CRC runs up to the trailer, then capture the trailer bytes
        total      = TOT_W'(OVERHEAD_BYTES) + TOT_W'(len_next);
        fcrc_next  = fcrc_in;
        latch_next = latch_reg;
        trail_next = trail_reg;
        if (pos_p2 < total)
        begin
            fcrc_next = crc16_byte(fcrc_in, b);
        end
        else if (pos_p2 == total)
        begin
            latch_next = fcrc_in;
            trail_next = {trail_reg[CRC16_W-1:BYTE_W], b};
        end
        else if (pos_p1 == total)
        begin
            trail_next = {b, trail_reg[BYTE_W-1:0]};
        end

        len_ok    = (len_next <= LEN_W'(MAX_PAYLOAD)) && (len_next <= LEN_W'(cfg.payload_limit));
        pay_end   = TOT_W'(PAYLOAD_START) + TOT_W'(len_next);
        in_window = (pos_reg >= POS_W'(PAYLOAD_START)) && (pos_w < pay_end);
        emit      = !s_word.last && start_ok_next && hmatch_next && len_ok && in_window;

        // Verdict checks in priority order
        if ((pos_p1 < TOT_W'(OVERHEAD_BYTES)) || !start_ok_next)
        begin
            vd = VERDICT_START;
        end
        else if (!len_ok || (pos_p1 < total))
        begin
            vd = VERDICT_LENGTH;
        end
        else if (!hmatch_next)
        begin
            vd = VERDICT_HDR_CRC;
        end
        else if (latch_next != trail_next)
        begin
            vd = VERDICT_FRAME_CRC;
        end
        else
        begin
            vd = VERDICT_OK;
        end

        good_next = good_reg;
        bad_next  = bad_reg;
        pos_next  = pos_reg;
        if (s_word.last)
        begin
            pos_next      = '0;
            start_ok_next = 1'b0;
            if (vd == VERDICT_OK)
            begin
                good_next = good_reg + CNT_W'(1);
            end
            else
            begin
                bad_next = bad_reg + CNT_W'(1);
            end
        end
        else if (pos_reg != POS_TOP)
        begin
            pos_next = pos_reg + POS_W'(1);
        end

        res = '0;
        if (s_word.last)
        begin
            res.kind    = KIND_VERDICT;
            res.verdict = vd;
            res.command = (vd == VERDICT_OK) ? cmd_next : '0;
            res.size    = (vd == VERDICT_START) ? '0 : len_next;
            res.good    = good_next;
            res.bad     = bad_next;
        end
        else
        begin
            res.kind   = KIND_PAYLOAD;
            res.value  = b;
            res.offset = OFF_W'(pos_reg - POS_W'(PAYLOAD_START));
        end
    end

    assign res_valid = s_take && (s_word.last || emit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            start_ok_reg <= 1'b0;
            good_reg     <= '0;
            bad_reg      <= '0;
        end
        else if (s_take)
        begin
            pos_reg      <= pos_next;
            start_ok_reg <= start_ok_next;
            good_reg     <= good_next;
            bad_reg      <= bad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            hcrc_reg   <= hcrc_next;
            hmatch_reg <= hmatch_next;
            fcrc_reg   <= fcrc_next;
            len_reg    <= len_next;
            cmd_reg    <= cmd_next;
            latch_reg  <= latch_next;
            trail_reg  <= trail_next;
        end
    end

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        s_take && s_word.last |=> (pos_reg == '0) && !start_ok_reg)
        else $error("position not cleared after a datagram end");

    a_verdict_out: assert property (@(posedge clk) disable iff (!rst_n)
        s_take && s_word.last |-> res_valid && (res.kind == KIND_VERDICT))
        else $error("datagram end gave no verdict");

    a_one_counter: assert property (@(posedge clk) disable iff (!rst_n)
        s_take && s_word.last |=>
            ((good_reg != $past(good_reg)) != (bad_reg != $past(bad_reg))))
        else $error("verdict must move exactly one counter");

    a_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_take && s_word.last) |=> $stable(good_reg) && $stable(bad_reg))
        else $error("counter moved without a verdict");

endmodule

`default_nettype wire

// File: design/fpv_out_stage.sv
`default_nettype none

module fpv_out_stage
    import fpv_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    res_valid,
    input  wire result_t res,
    output logic         res_ready,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_res
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // Load when empty or when the held result is taken this cycle
    assign res_ready = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_ready)
        begin
            valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && (res_reg.kind == KIND_PAYLOAD) |->
            (res_reg.verdict == VERDICT_OK) && (res_reg.good == '0) && (res_reg.bad == '0))
        else $error("payload word carries verdict fields");

endmodule

`default_nettype wire
